@@ rtl/core/c_subset_token_scanner_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the C subset token scanner
// Shared wrappers for clocked checks; the using scope provides clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef C_SUBSET_TOKEN_SCANNER_MACROS_SVH
`define C_SUBSET_TOKEN_SCANNER_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define CSCAN_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante
`define CSCAN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/cscan_pkg.sv @@
// ---------------------------------------------------------------------------
// C subset token scanner package
// Token kind codes, scan modes, character codes and shared control types.
// ---------------------------------------------------------------------------
package cscan_pkg;

  // Fixed field widths of one token
  localparam int KIND_BITS  = 5;
  localparam int LEN_BITS   = 16;
  localparam int VALUE_BITS = 63;
  localparam int CHAR_BITS  = 8;

  // Token fields whose width does not follow a parameter (kind, length, value,
  // overflow flag, invalid byte, last flag)
  localparam int TOK_FIXED_BITS = KIND_BITS + LEN_BITS + VALUE_BITS + 1 + CHAR_BITS + 1;

  // Blank characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_END,
    KIND_IDENT,
    KIND_NUMBER,
    KIND_INT,
    KIND_RETURN,
    KIND_IF,
    KIND_ELSE,
    KIND_WHILE,
    KIND_FOR,
    KIND_EQ,
    KIND_NE,
    KIND_LE,
    KIND_GE,
    KIND_PLUS,
    KIND_MINUS,
    KIND_STAR,
    KIND_SLASH,
    KIND_PERCENT,
    KIND_ASSIGN,
    KIND_LT,
    KIND_GT,
    KIND_LPAREN,
    KIND_RPAREN,
    KIND_LBRACE,
    KIND_RBRACE,
    KIND_SEMI,
    KIND_COMMA,
    KIND_INVALID
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_PEND,
    MODE_COMMENT
  } mode_t;

  // Tokens produced by one scan step: slot 0 first, slot 1 second
  typedef struct packed {
    logic vld0;
    logic vld1;
  } emit_t;

endpackage

@@ rtl/core/cscan_core.sv @@
// ---------------------------------------------------------------------------
// C subset token scanner core
// Holds the scanner state and turns one byte per step into up to two tokens.
// ---------------------------------------------------------------------------
module cscan_core #(
  parameter int LINE_BITS   = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_i,
  input  logic [7:0]            byte_i,
  input  logic                  end_i,
  output cscan_pkg::emit_t      emit_o,
  output logic [cscan_pkg::TOK_FIXED_BITS+2*LINE_BITS+OFFSET_BITS-1:0] tok0_o,
  output logic [cscan_pkg::TOK_FIXED_BITS+2*LINE_BITS+OFFSET_BITS-1:0] tok1_o
);

  typedef struct packed {
    cscan_pkg::kind_t                   kind;
    logic [LINE_BITS-1:0]               line;
    logic [LINE_BITS-1:0]               col;
    logic [OFFSET_BITS-1:0]             off;
    logic [cscan_pkg::LEN_BITS-1:0]     len;
    logic [cscan_pkg::VALUE_BITS-1:0]   value;
    logic                               ovf;
    logic [cscan_pkg::CHAR_BITS-1:0]    inv;
    logic                               last;
  } tok_t;

  // Character classes
  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    is_blank = c == cscan_pkg::CH_SPACE || c == cscan_pkg::CH_TAB ||
               c == cscan_pkg::CH_CR || c == cscan_pkg::CH_LF;
  endfunction

  function automatic logic is_pend(input logic [7:0] c);
    is_pend = c == "=" || c == "!" || c == "<" || c == ">" || c == "/";
  endfunction

  // Single character token kind, invalid for anything unlisted
  function automatic cscan_pkg::kind_t single_kind(input logic [7:0] c);
    unique case (c)
      "+":     single_kind = cscan_pkg::KIND_PLUS;
      "-":     single_kind = cscan_pkg::KIND_MINUS;
      "*":     single_kind = cscan_pkg::KIND_STAR;
      "/":     single_kind = cscan_pkg::KIND_SLASH;
      "%":     single_kind = cscan_pkg::KIND_PERCENT;
      "=":     single_kind = cscan_pkg::KIND_ASSIGN;
      "<":     single_kind = cscan_pkg::KIND_LT;
      ">":     single_kind = cscan_pkg::KIND_GT;
      "(":     single_kind = cscan_pkg::KIND_LPAREN;
      ")":     single_kind = cscan_pkg::KIND_RPAREN;
      "{":     single_kind = cscan_pkg::KIND_LBRACE;
      "}":     single_kind = cscan_pkg::KIND_RBRACE;
      ";":     single_kind = cscan_pkg::KIND_SEMI;
      ",":     single_kind = cscan_pkg::KIND_COMMA;
      default: single_kind = cscan_pkg::KIND_INVALID;
    endcase
  endfunction

  // Two character comparison kind from the held first character
  function automatic cscan_pkg::kind_t cmp_kind(input logic [7:0] c);
    unique case (c)
      "=":     cmp_kind = cscan_pkg::KIND_EQ;
      "!":     cmp_kind = cscan_pkg::KIND_NE;
      "<":     cmp_kind = cscan_pkg::KIND_LE;
      default: cmp_kind = cscan_pkg::KIND_GE;
    endcase
  endfunction

  // Keyword match on the whole text; unused trailing bytes stay zero
  function automatic cscan_pkg::kind_t ident_kind(input logic [15:0] len,
                                                  input logic [47:0] txt);
    ident_kind = cscan_pkg::KIND_IDENT;
    if (len == 16'd3 && txt == {"int", 24'h0}) ident_kind = cscan_pkg::KIND_INT;
    if (len == 16'd6 && txt == "return") ident_kind = cscan_pkg::KIND_RETURN;
    if (len == 16'd2 && txt == {"if", 32'h0}) ident_kind = cscan_pkg::KIND_IF;
    if (len == 16'd4 && txt == {"else", 16'h0}) ident_kind = cscan_pkg::KIND_ELSE;
    if (len == 16'd5 && txt == {"while", 8'h0}) ident_kind = cscan_pkg::KIND_WHILE;
    if (len == 16'd3 && txt == {"for", 24'h0}) ident_kind = cscan_pkg::KIND_FOR;
  endfunction

  cscan_pkg::mode_t           mode_r, mode_nxt;
  logic [LINE_BITS-1:0]       line_r, line_nxt;
  logic [LINE_BITS-1:0]       col_r, col_nxt;
  logic [OFFSET_BITS-1:0]     pos_r, pos_nxt;
  logic [LINE_BITS-1:0]       sline_r, sline_nxt;
  logic [LINE_BITS-1:0]       scol_r, scol_nxt;
  logic [OFFSET_BITS-1:0]     soff_r, soff_nxt;
  logic [15:0]                len_r, len_nxt;
  logic [62:0]                acc_r, acc_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [7:0]                 pend_r, pend_nxt;
  logic [7:0]                 kw_r [6];
  logic [7:0]                 kw_nxt [6];

  logic [66:0]                acc_sum;
  logic                       acc_over;
  logic                       restart;
  tok_t                       fin;
  tok_t                       st;
  logic                       fin_vld;
  logic                       st_vld;
  tok_t                       tok0;
  tok_t                       tok1;

  // Decimal accumulate: acc * 10 + digit as two shifted adds
  assign acc_sum  = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {63'd0, byte_i[3:0]};
  assign acc_over = |acc_sum[66:63];

  // Next state and tokens for one step
  always_comb begin
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    pos_nxt   = pos_r;
    sline_nxt = sline_r;
    scol_nxt  = scol_r;
    soff_nxt  = soff_r;
    len_nxt   = len_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    pend_nxt  = pend_r;
    kw_nxt    = kw_r;
    restart   = 1'b0;
    fin_vld   = 1'b0;
    st_vld    = 1'b0;

    // Token closed by this step, as the open token stands
    fin      = '0;
    fin.line = sline_r;
    fin.col  = scol_r;
    fin.off  = soff_r;
    unique case (mode_r)
      cscan_pkg::MODE_IDENT: begin
        fin.kind = ident_kind(len_r, {kw_r[0], kw_r[1], kw_r[2], kw_r[3], kw_r[4], kw_r[5]});
        fin.len  = len_r;
      end
      cscan_pkg::MODE_NUMBER: begin
        fin.kind  = cscan_pkg::KIND_NUMBER;
        fin.len   = len_r;
        fin.value = acc_r;
        fin.ovf   = ovf_r;
      end
      cscan_pkg::MODE_PEND: begin
        fin.kind = single_kind(pend_r);
        fin.len  = 16'd1;
        fin.inv  = (single_kind(pend_r) == cscan_pkg::KIND_INVALID) ? pend_r : 8'h00;
      end
      default: begin
        fin.kind = cscan_pkg::KIND_END;
      end
    endcase

    // Token that starts at the current position
    st      = '0;
    st.line = line_r;
    st.col  = col_r;
    st.off  = pos_r;

    if (end_i) begin
      // Flush the open token, emit End, return to reset state
      fin_vld  = mode_r == cscan_pkg::MODE_IDENT || mode_r == cscan_pkg::MODE_NUMBER ||
                 mode_r == cscan_pkg::MODE_PEND;
      st.kind  = cscan_pkg::KIND_END;
      st_vld   = 1'b1;
      mode_nxt = cscan_pkg::MODE_IDLE;
      line_nxt = LINE_BITS'(1);
      col_nxt  = LINE_BITS'(1);
      pos_nxt  = '0;
    end else begin
      unique case (mode_r)
        cscan_pkg::MODE_COMMENT: begin
          if (byte_i == cscan_pkg::CH_LF) begin
            mode_nxt = cscan_pkg::MODE_IDLE;
          end
        end
        cscan_pkg::MODE_IDENT: begin
          if (is_letter(byte_i) || is_digit(byte_i)) begin
            for (int i = 0; i < 6; i++) begin
              if (len_r == 16'(i)) kw_nxt[i] = byte_i;
            end
            len_nxt = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;
          end else begin
            restart = 1'b1;
          end
        end
        cscan_pkg::MODE_NUMBER: begin
          if (is_digit(byte_i)) begin
            if (acc_over) begin
              acc_nxt = '1;
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = acc_sum[62:0];
            end
            len_nxt = (len_r == 16'hFFFF) ? len_r : len_r + 16'd1;
          end else begin
            restart = 1'b1;
          end
        end
        cscan_pkg::MODE_PEND: begin
          if (pend_r == "/" && byte_i == "/") begin
            mode_nxt = cscan_pkg::MODE_COMMENT;
          end else if (byte_i == "=" && pend_r != "/") begin
            fin.kind = cmp_kind(pend_r);
            fin.len  = 16'd2;
            fin.inv  = 8'h00;
            fin_vld  = 1'b1;
            mode_nxt = cscan_pkg::MODE_IDLE;
          end else begin
            restart = 1'b1;
          end
        end
        default: begin
          restart = 1'b1;
        end
      endcase

      // Close the open token and start a new one from this byte
      if (restart) begin
        fin_vld  = mode_r != cscan_pkg::MODE_IDLE;
        mode_nxt = cscan_pkg::MODE_IDLE;
        if (!is_blank(byte_i)) begin
          sline_nxt = line_r;
          scol_nxt  = col_r;
          soff_nxt  = pos_r;
          len_nxt   = 16'd1;
          if (is_letter(byte_i)) begin
            for (int i = 0; i < 6; i++) kw_nxt[i] = 8'h00;
            kw_nxt[0] = byte_i;
            mode_nxt  = cscan_pkg::MODE_IDENT;
          end else if (is_digit(byte_i)) begin
            acc_nxt  = {59'd0, byte_i[3:0]};
            ovf_nxt  = 1'b0;
            mode_nxt = cscan_pkg::MODE_NUMBER;
          end else if (is_pend(byte_i)) begin
            pend_nxt = byte_i;
            mode_nxt = cscan_pkg::MODE_PEND;
          end else begin
            st.kind = single_kind(byte_i);
            st.len  = 16'd1;
            st.inv  = (single_kind(byte_i) == cscan_pkg::KIND_INVALID) ? byte_i : 8'h00;
            st_vld  = 1'b1;
          end
        end
      end

      // Advance the position past this byte, saturating
      pos_nxt = (pos_r == '1) ? pos_r : pos_r + OFFSET_BITS'(1);
      if (byte_i == cscan_pkg::CH_LF) begin
        line_nxt = (line_r == '1) ? line_r : line_r + LINE_BITS'(1);
        col_nxt  = LINE_BITS'(1);
      end else begin
        col_nxt  = (col_r == '1) ? col_r : col_r + LINE_BITS'(1);
      end
    end
  end

  // Order the tokens and mark the last one of the step
  always_comb begin
    tok0      = fin_vld ? fin : st;
    tok0.last = !(fin_vld && st_vld);
    tok1      = st;
    tok1.last = 1'b1;
  end

  assign emit_o.vld0 = fin_vld || st_vld;
  assign emit_o.vld1 = fin_vld && st_vld;
  assign tok0_o      = tok0;
  assign tok1_o      = tok1;

  // Control state and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cscan_pkg::MODE_IDLE;
      line_r <= LINE_BITS'(1);
      col_r  <= LINE_BITS'(1);
      pos_r  <= '0;
    end else if (step_i) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
      pos_r  <= pos_nxt;
    end
  end

  // Open token payload, always set when a token starts
  always_ff @(posedge clk) begin
    if (step_i) begin
      sline_r <= sline_nxt;
      scol_r  <= scol_nxt;
      soff_r  <= soff_nxt;
      len_r   <= len_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      pend_r  <= pend_nxt;
      kw_r    <= kw_nxt;
    end
  end

endmodule

@@ rtl/core/cscan_outbuf.sv @@
// ---------------------------------------------------------------------------
// C subset token scanner result buffer
// Two token slots loaded per scan step, one beat out per unstalled cycle.
// ---------------------------------------------------------------------------
module cscan_outbuf #(
  parameter int DATA_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load_i,
  input  cscan_pkg::emit_t      emit_i,
  input  logic [DATA_W-1:0]     d0_i,
  input  logic [DATA_W-1:0]     d1_i,
  output logic                  ready_o,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     out_data
);

  logic              v0_r, v0_nxt;
  logic              v1_r, v1_nxt;
  logic [DATA_W-1:0] d0_r;
  logic [DATA_W-1:0] d1_r;
  logic              pop;

  // Present slot 0 first, then slot 1
  assign out_valid = v0_r || v1_r;
  assign out_data  = v0_r ? d0_r : d1_r;
  assign pop       = out_valid && !out_stall;

  // Take a new step only when both slots are free after this cycle's beat
  assign ready_o = !out_valid || (pop && !(v0_r && v1_r));

  always_comb begin
    v0_nxt = v0_r;
    v1_nxt = v1_r;
    if (load_i) begin
      v0_nxt = emit_i.vld0;
      v1_nxt = emit_i.vld1;
    end else if (pop) begin
      if (v0_r) begin
        v0_nxt = 1'b0;
      end else begin
        v1_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
    end
  end

  // Hold slot data until the next load
  always_ff @(posedge clk) begin
    if (load_i) begin
      d0_r <= d0_i;
      d1_r <= d1_i;
    end
  end

endmodule

@@ rtl/core/c_subset_token_scanner.sv @@
// ---------------------------------------------------------------------------
// C subset token scanner
// Streaming lexer for a small C subset with per-token position and length.
// ---------------------------------------------------------------------------
// The scanner takes one source byte per beat and accepts a new beat every
// cycle while in_stall is low; the beat goes into an input register, is
// scanned once the result buffer has room, and its tokens land in a
// two-slot result buffer. Tokens leave one beat per cycle while out_stall is
// low, so a byte that both closes a token and emits one (or the end marker
// after an open token) holds the input until its second token leaves; that
// single result port sets the rate. An identifier, a number or a lone
// = ! < > / is only reported once the byte after it is seen, and a beat with
// in_is_end set flushes the open token, emits End (flagged as last of its
// run) and returns the scanner to its reset position.
// ---------------------------------------------------------------------------
`include "c_subset_token_scanner_macros.svh"

module c_subset_token_scanner #(
  parameter int LINE_BITS   = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              in_text_byte,
  input  logic                    in_is_end,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [4:0]              out_token_kind,
  output logic [LINE_BITS-1:0]    out_start_line,
  output logic [LINE_BITS-1:0]    out_start_column,
  output logic [OFFSET_BITS-1:0]  out_start_offset,
  output logic [15:0]             out_lexeme_length,
  output logic [62:0]             out_number_value,
  output logic                    out_number_overflow,
  output logic [7:0]              out_invalid_char,
  output logic                    out_last_of_run
);

  localparam int TOK_W = cscan_pkg::TOK_FIXED_BITS + 2 * LINE_BITS + OFFSET_BITS;

  typedef struct packed {
    cscan_pkg::kind_t                   kind;
    logic [LINE_BITS-1:0]               line;
    logic [LINE_BITS-1:0]               col;
    logic [OFFSET_BITS-1:0]             off;
    logic [cscan_pkg::LEN_BITS-1:0]     len;
    logic [cscan_pkg::VALUE_BITS-1:0]   value;
    logic                               ovf;
    logic [cscan_pkg::CHAR_BITS-1:0]    inv;
    logic                               last;
  } tok_t;

  logic             in_vld_r, in_vld_nxt;
  logic [7:0]       in_byte_r;
  logic             in_end_r;
  logic             in_acc;
  logic             ready;
  logic             step;
  cscan_pkg::emit_t emit;
  logic [TOK_W-1:0] tok0;
  logic [TOK_W-1:0] tok1;
  logic [TOK_W-1:0] out_data;
  tok_t             out_tok;

  // Input register: scan the held beat when the result buffer has room
  assign step       = in_vld_r && ready;
  assign in_stall   = in_vld_r && !ready;
  assign in_acc     = in_valid && !in_stall;
  assign in_vld_nxt = in_acc || (in_vld_r && !step);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_text_byte;
      in_end_r  <= in_is_end;
    end
  end

  cscan_core #(
    .LINE_BITS   (LINE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .byte_i (in_byte_r),
    .end_i  (in_end_r),
    .emit_o (emit),
    .tok0_o (tok0),
    .tok1_o (tok1)
  );

  cscan_outbuf #(
    .DATA_W (TOK_W)
  ) u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (step),
    .emit_i    (emit),
    .d0_i      (tok0),
    .d1_i      (tok1),
    .ready_o   (ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Unpack the result beat onto the ports
  assign out_tok             = out_data;
  assign out_token_kind      = out_tok.kind;
  assign out_start_line      = out_tok.line;
  assign out_start_column    = out_tok.col;
  assign out_start_offset    = out_tok.off;
  assign out_lexeme_length   = out_tok.len;
  assign out_number_value    = out_tok.value;
  assign out_number_overflow = out_tok.ovf;
  assign out_invalid_char    = out_tok.inv;
  assign out_last_of_run     = out_tok.last;

  // End always closes the run of its beat and has no length
  `CSCAN_ASSERT_SAME(a_end_last, out_valid && out_tok.kind == cscan_pkg::KIND_END,
    out_last_of_run && out_lexeme_length == 16'd0, "End token not last of run or has length")
  // Only number tokens carry a value
  `CSCAN_ASSERT_SAME(a_value_kind, out_valid && out_number_value != '0,
    out_tok.kind == cscan_pkg::KIND_NUMBER, "Nonzero value on a non-number token")
  // An overflowed number is held at its saturated value
  `CSCAN_ASSERT_SAME(a_ovf_sat, out_valid && out_number_overflow,
    out_number_value == '1 && out_tok.kind == cscan_pkg::KIND_NUMBER,
    "Overflowed number not saturated")
  // A scanned beat never lands while an earlier token still waits
  `CSCAN_ASSERT_NEXT(a_step_drained, step, $past(!out_valid || !out_stall),
    "Scan step over a waiting token")

endmodule
